>>> rtl/assert_macros.svh
// Assertion macros used by the top level of the indexed list.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ILI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ILI_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/ili_pkg.sv
// Types and constants of the indexed list block.
package ili_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;

  typedef enum logic [2:0] {
    KIND_CLEAR     = 3'd0,
    KIND_INSERT    = 3'd1,
    KIND_OVERWRITE = 3'd2,
    KIND_DELETE    = 3'd3,
    KIND_READ      = 3'd4,
    KIND_DUMP      = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_OVW,
    CELL_DEL,
    CELL_ROT
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_ROT
  } state_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_e         op;
    logic [POS_W-1:0] pos;       // target position of an edit
    logic [CNT_W-1:0] last_idx;  // highest occupied position during rotation
  } cell_cmd_t;

endpackage

>>> rtl/ili_cell.sv
// One storage cell of the list chain.
module ili_cell
  import ili_pkg::*;
(
  input  logic                    clk_i,
  input  cell_cmd_t               cmd_i,
  input  logic [IDX_W-1:0]        idx_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic signed [VAL_W-1:0] left_i,
  input  logic signed [VAL_W-1:0] right_i,
  input  logic signed [VAL_W-1:0] wrap_i,
  output logic signed [VAL_W-1:0] entry_o
);

  logic signed [VAL_W-1:0] entry_q, entry_d;
  logic [POS_W-1:0]        my_pos;

  assign my_pos = {1'b0, idx_i};

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      CELL_INS: begin
        if (my_pos > cmd_i.pos) begin
          entry_d = left_i;
        end else if (my_pos == cmd_i.pos) begin
          entry_d = value_i;
        end
      end
      CELL_OVW: begin
        if (my_pos == cmd_i.pos) begin
          entry_d = value_i;
        end
      end
      CELL_DEL: begin
        if (my_pos >= cmd_i.pos) begin
          entry_d = right_i;
        end
      end
      CELL_ROT: begin
        // close the ring at the last occupied cell
        if (my_pos == cmd_i.last_idx) begin
          entry_d = wrap_i;
        end else if (my_pos < cmd_i.last_idx) begin
          entry_d = right_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> rtl/indexed_list_insert_delete.sv
// Top level of the indexed list: a chain of entry cells with its sequencer and output register.
// An ordered list of up to 64 signed 32-bit entries, held in a row of cells
// that shift as one. Each input transaction carries a kind in tuser and a
// position and value in tdata. Clear, insert, overwrite and delete finish in
// the cycle they are accepted: all cells shift or load together, so the next
// transaction can follow right away while the output register is free. Read and
// dump rotate the occupied part of the chain once through cell 0, one step
// per cycle; a read or a dump holds off input until its rotation is through,
// and either one additionally waits whenever the output register holds a
// result that the master side has not taken. Errors (full, empty, bad
// position) leave the store untouched and return one result with an error
// status. A single output register sits between the chain and the master
// side, so an input can be accepted in the same cycle that the previous
// result is taken. The entries have no reset; only positions below the count
// are ever read.
`include "assert_macros.svh"

module indexed_list_insert_delete
  import ili_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // position[6:0], value[38:7], zero pad
  input  logic [2:0]  s_axis_tuser_i,   // kind[2:0]
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // status[1:0], data[33:2], index[39:34],
                                        // count[46:40], zero pad
  output logic        m_axis_tlast_o
);

  // input unpacking
  logic [POS_W-1:0]        in_pos;
  logic signed [VAL_W-1:0] in_value;
  logic [2:0]              in_kind;
  logic                    in_acc;
  logic                    out_free;

  assign in_pos   = s_axis_tdata_i[6:0];
  assign in_value = s_axis_tdata_i[38:7];
  assign in_kind  = s_axis_tuser_i;

  // control state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic             dump_q, dump_d;
  logic [IDX_W-1:0] rpos_q, rpos_d;
  logic             m_valid_q, m_valid_d;

  // output payload register
  logic [1:0]              m_status_q;
  logic signed [VAL_W-1:0] m_data_q;
  logic [IDX_W-1:0]        m_index_q;
  logic [CNT_W-1:0]        m_count_q;
  logic                    m_last_q;

  // result being formed this cycle
  logic                    out_load;
  status_e                 res_status;
  logic signed [VAL_W-1:0] res_data;
  logic [IDX_W-1:0]        res_index;
  logic [CNT_W-1:0]        res_count;
  logic                    res_last;

  logic [CNT_W-1:0] last_idx;
  logic             rot_start;
  logic             rot_done;

  cell_cmd_t               cmd;
  logic signed [VAL_W-1:0] entry_w [DEPTH];

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign last_idx        = count_q - CNT_W'(1);
  assign rot_done        = out_free && ({1'b0, step_q} == last_idx);

  // A dump with a nonempty list, or a read with a valid position, starts a rotation.
  always_comb begin
    rot_start = 1'b0;
    if (in_acc && count_q != '0) begin
      if (in_kind == KIND_DUMP) begin
        rot_start = 1'b1;
      end else if (in_kind == KIND_READ && in_pos < count_q) begin
        rot_start = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (rot_start) begin
          state_d = ST_ROT;
        end
      end
      ST_ROT: begin
        if (rot_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs: cell command, results and counters
  always_comb begin
    cmd.op       = CELL_HOLD;
    cmd.pos      = in_pos;
    cmd.last_idx = last_idx;
    count_d      = count_q;
    step_d       = step_q;
    dump_d       = dump_q;
    rpos_d       = rpos_q;
    out_load     = 1'b0;
    res_status   = STAT_OK;
    res_data     = '0;
    res_index    = '0;
    res_count    = count_q;
    res_last     = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            KIND_CLEAR: begin
              count_d   = '0;
              out_load  = 1'b1;
              res_count = '0;
            end
            KIND_INSERT: begin
              out_load = 1'b1;
              if (count_q >= CNT_W'(DEPTH)) begin
                res_status = STAT_FULL;
              end else if (in_pos > count_q) begin
                res_status = STAT_RANGE;
              end else begin
                cmd.op    = CELL_INS;
                count_d   = count_q + CNT_W'(1);
                res_count = count_d;
              end
            end
            KIND_OVERWRITE, KIND_DELETE, KIND_READ: begin
              if (count_q == '0) begin
                out_load   = 1'b1;
                res_status = STAT_EMPTY;
              end else if (in_pos >= count_q) begin
                out_load   = 1'b1;
                res_status = STAT_RANGE;
              end else if (in_kind == KIND_OVERWRITE) begin
                out_load = 1'b1;
                cmd.op   = CELL_OVW;
              end else if (in_kind == KIND_DELETE) begin
                out_load  = 1'b1;
                cmd.op    = CELL_DEL;
                count_d   = count_q - CNT_W'(1);
                res_count = count_d;
              end else begin
                // read: rotate and pick the entry as it passes cell 0
                step_d = '0;
                dump_d = 1'b0;
                rpos_d = in_pos[IDX_W-1:0];
              end
            end
            KIND_DUMP: begin
              if (count_q == '0) begin
                out_load   = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                step_d = '0;
                dump_d = 1'b1;
              end
            end
            default: begin
              // unused kinds: acknowledge without change
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_ROT: begin
        if (out_free) begin
          cmd.op = CELL_ROT;
          step_d = step_q + IDX_W'(1);
          if (dump_q || step_q == rpos_q) begin
            out_load  = 1'b1;
            res_data  = entry_w[0];
            res_index = step_q;
            res_last  = dump_q ? ({1'b0, step_q} == last_idx) : 1'b1;
          end
        end
      end
      default: begin
        cmd.op = CELL_HOLD;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      step_q    <= '0;
      dump_q    <= 1'b0;
      rpos_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      step_q    <= step_d;
      dump_q    <= dump_d;
      rpos_q    <= rpos_d;
      m_valid_q <= m_valid_d;
    end
  end

  // hold the payload until a new result replaces it
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_status_q <= res_status;
      m_data_q   <= res_data;
      m_index_q  <= res_index;
      m_count_q  <= res_count;
      m_last_q   <= res_last;
    end
  end

  // the chain: each cell sees its neighbors and cell 0 for the ring closure
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry_w[g+1];
    end
    ili_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (IDX_W'(g)),
      .value_i (in_value),
      .left_i  (left_w),
      .right_i (right_w),
      .wrap_i  (entry_w[0]),
      .entry_o (entry_w[g])
    );
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_count_q, m_index_q, m_data_q, m_status_q};
  assign m_axis_tlast_o  = m_last_q;

  `ILI_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count above capacity")
  `ILI_ASSERT_NEXT(a_rot_keeps_count, state_q == ST_ROT, count_q == $past(count_q),
                   "count changed during rotation")
  `ILI_ASSERT_NEXT(a_dump_end, state_q == ST_ROT && out_load && dump_q && res_last,
                   state_q == ST_IDLE, "dump run did not end with its last result")
  `ILI_ASSERT_NEXT(a_ins_count,
                   in_acc && in_kind == KIND_INSERT && count_q < CNT_W'(DEPTH) &&
                   in_pos <= count_q,
                   count_q == $past(count_q) + CNT_W'(1), "insert did not grow the list")

endmodule
